// ===== rtl/core/bertlv_pkg.sv =====
// Package: codes, widths and constants for the BER TLV element decoder.
package bertlv_pkg;

    localparam int LEN_BYTES = 4;
    localparam int INT_BYTES = 4;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_LEN_FIRST = 4'b0010,
        PH_LEN_MORE = 4'b0100,
        PH_CONTENT  = 4'b1000
    } t_phase;

    localparam logic [2:0] K_SKIP   = 3'd0;
    localparam logic [2:0] K_HEADER = 3'd1;
    localparam logic [2:0] K_INT    = 3'd2;
    localparam logic [2:0] K_OCTETS = 3'd3;
    localparam logic [2:0] K_OID    = 3'd4;

    localparam logic [2:0] R_LEN  = 3'd0;
    localparam logic [2:0] R_INT  = 3'd1;
    localparam logic [2:0] R_BYTE = 3'd2;
    localparam logic [2:0] R_ARC  = 3'd3;
    localparam logic [2:0] R_DONE = 3'd4;
    localparam logic [2:0] R_ERR  = 3'd5;

    localparam logic [3:0] E_END_TAG     = 4'd0;
    localparam logic [3:0] E_TAG         = 4'd1;
    localparam logic [3:0] E_END_LEN     = 4'd2;
    localparam logic [3:0] E_INDEF      = 4'd3;
    localparam logic [3:0] E_LEN_LARGE   = 4'd4;
    localparam logic [3:0] E_LENF_BUF    = 4'd5;
    localparam logic [3:0] E_LEN_BUF     = 4'd6;
    localparam logic [3:0] E_INT_ZERO    = 4'd7;
    localparam logic [3:0] E_INT_LONG    = 4'd8;
    localparam logic [3:0] E_OID_ZERO    = 4'd9;
    localparam logic [3:0] E_ARC_OPEN    = 4'd10;

    // one result item: kind, value, error code and last flag
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [32:0] value;
        logic [3:0]         err;
        logic               last;
    } t_res;

    localparam int MAXR = 3;

endpackage

// ===== rtl/core/ber_tlv_element_decoder_unit.sv =====
// Top level: streaming BER TLV element decoder.
//
// Usage:
//  Slave channel: one buffer byte per item. s_axis_tuser carries kind and
//  start_req, s_axis_tdata carries expected_tag, byte_value and bytes_left.
//  A start_req item opens a request.
//  Master channel: result items; m_axis_tuser gives the result kind (length,
//  integer, content byte, oid arc, done, error), m_axis_tdata the value and
//  error code, and tlast marks the final result of an element.
//  An input item is registered, then decoded in one pass into at most two
//  results, appended to a three-entry result register that drains one per
//  cycle while m_axis_tready is high. An accepted item passes through the
//  input register and then the result register before its first result shows.
//  Throughput: one input item per cycle while each item gives at most one
//  result and the receiver keeps taking results; an oid first byte gives two
//  results, and an item is decoded only while at most one result remains
//  queued after the pop, so the input is held otherwise until the queue drains.
//  Reset (i_rst_n low, synchronous) returns to idle awaiting a tag with all
//  accumulators cleared and no results pending.
//  A stalled receiver (m_axis_tready low) holds the current result; input
//  keeps flowing while the result register and input register have room.
module ber_tlv_element_decoder_unit
    import bertlv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] expected_tag, [15:8] byte_value, [31:16] bytes_left
    input  logic [31:0] s_axis_tdata,
    // [2:0] kind, [3] start_req
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [32:0] result_value, [36:33] error_code, [39:37] zero
    output logic [39:0] m_axis_tdata,
    // [2:0] result_kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    // input register
    logic        r_iv;
    logic [35:0] r_in;

    // architectural state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_ekind, n_ekind;
    logic [3:0]  r_lbr, n_lbr;
    logic [31:0] r_lacc, n_lacc;
    logic [31:0] r_crem, n_crem;
    logic [31:0] r_iacc, n_iacc;
    logic [31:0] r_aacc, n_aacc;
    logic        r_first, n_first;

    // result queue, up to 3 entries
    t_res        r_q [MAXR];
    logic [1:0]  r_qn;
    t_res        n_r [MAXR];
    logic [1:0]  n_cnt;

    logic        pop, consume, in_fire;
    logic [2:0]  in_kind;
    logic        in_start;
    logic [7:0]  in_tag, in_b;
    logic [15:0] in_left, room;

    assign in_kind  = r_in[2:0];
    assign in_start = r_in[3];
    assign in_tag   = r_in[11:4];
    assign in_b     = r_in[19:12];
    assign in_left  = r_in[35:20];
    assign room     = (in_left != 16'd0) ? in_left - 16'd1 : 16'd0;

    assign pop = m_axis_tvalid && m_axis_tready;
    // registered item is decoded when queue has room for 2 after this pop
    logic [1:0] q_after;
    assign q_after = r_qn - {1'b0, pop};
    assign consume = r_iv && (q_after <= 2'd1);
    assign s_axis_tready = !r_iv || consume;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    function automatic t_res mk(input logic [2:0] k, input logic signed [32:0] v,
                                input logic [3:0] e, input logic l);
        t_res t;
        t.kind = k; t.value = v; t.err = e; t.last = l;
        return t;
    endfunction

    // decode pass
    always_comb begin
        logic [31:0] len;
        logic        len_done;
        logic [6:0]  cnt;
        logic        fin;
        logic [31:0] ia;
        logic [31:0] aa;
        logic [7:0]  q40, r40;
        n_phase = r_phase; n_ekind = r_ekind; n_lbr = r_lbr; n_lacc = r_lacc;
        n_crem = r_crem; n_iacc = r_iacc; n_aacc = r_aacc; n_first = r_first;
        n_r[0] = mk(R_ERR, '0, '0, 1'b0);
        n_r[1] = n_r[0];
        n_r[2] = n_r[0];
        n_cnt = 2'd0;
        len = '0; len_done = 1'b0; cnt = in_b[6:0]; fin = 1'b0;
        ia = '0; aa = '0;
        q40 = 8'((16'(in_b) * 16'd205) >> 13);
        r40 = in_b - 8'(q40 * 8'd40);
        if (in_start) begin
            n_ekind = (in_kind <= K_OID) ? in_kind : K_SKIP;
            if (in_left == 16'd0) begin
                n_r[0] = mk(R_ERR, '0, E_END_TAG, 1'b1); n_cnt = 2'd1; n_phase = PH_IDLE;
            end else if (n_ekind != K_SKIP && in_b != in_tag) begin
                n_r[0] = mk(R_ERR, '0, E_TAG, 1'b1); n_cnt = 2'd1; n_phase = PH_IDLE;
            end else begin
                n_phase = PH_LEN_FIRST;
            end
        end else begin
            unique case (r_phase)
                PH_LEN_FIRST: begin
                    if (in_left == 16'd0) begin
                        n_r[0] = mk(R_ERR, '0, E_END_LEN, 1'b1); n_cnt = 2'd1;
                        n_phase = PH_IDLE;
                    end else if (!in_b[7]) begin
                        len = {24'd0, in_b}; len_done = 1'b1;
                    end else if (cnt == 7'd0) begin
                        n_r[0] = mk(R_ERR, '0, E_INDEF, 1'b1); n_cnt = 2'd1;
                        n_phase = PH_IDLE;
                    end else if (cnt > 7'(LEN_BYTES)) begin
                        n_r[0] = mk(R_ERR, '0, E_LEN_LARGE, 1'b1); n_cnt = 2'd1;
                        n_phase = PH_IDLE;
                    end else if (16'(cnt) > room) begin
                        n_r[0] = mk(R_ERR, '0, E_LENF_BUF, 1'b1); n_cnt = 2'd1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_lbr = cnt[3:0]; n_lacc = '0; n_phase = PH_LEN_MORE;
                    end
                end
                PH_LEN_MORE: begin
                    if (in_left == 16'd0) begin
                        n_r[0] = mk(R_ERR, '0, E_END_LEN, 1'b1); n_cnt = 2'd1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_lacc = (r_lacc > 32'h00FF_FFFF) ? 32'hFFFF_FFFF
                                                          : {r_lacc[23:0], in_b};
                        n_lbr = (r_lbr != 4'd0) ? r_lbr - 4'd1 : 4'd0;
                        if (n_lbr == 4'd0) begin
                            len = n_lacc; len_done = 1'b1;
                        end
                    end
                end
                PH_CONTENT: begin
                    fin = (r_crem <= 32'd1);
                    n_crem = fin ? 32'd0 : r_crem - 32'd1;
                    unique case (r_ekind)
                        K_INT: begin
                            ia = r_first ? {32{in_b[7]}} : r_iacc;
                            n_iacc = {ia[23:0], in_b};
                            if (fin) begin
                                n_r[0] = mk(R_INT, {n_iacc[31], n_iacc}, '0, 1'b1);
                                n_cnt = 2'd1;
                            end
                        end
                        K_OCTETS: begin
                            n_r[0] = mk(R_BYTE, {25'd0, in_b}, '0, fin); n_cnt = 2'd1;
                        end
                        K_OID: begin
                            if (r_first) begin
                                n_r[0] = mk(R_ARC, {25'd0, q40}, '0, 1'b0);
                                n_r[1] = mk(R_ARC, {25'd0, r40}, '0, fin);
                                n_cnt = 2'd2;
                            end else begin
                                aa = {r_aacc[24:0], in_b[6:0]};
                                n_aacc = aa;
                                if (!in_b[7]) begin
                                    n_r[0] = mk(R_ARC, {1'b0, aa}, '0, fin);
                                    n_cnt = 2'd1; n_aacc = '0;
                                end else if (fin) begin
                                    n_r[0] = mk(R_ERR, '0, E_ARC_OPEN, 1'b1);
                                    n_cnt = 2'd1;
                                end
                            end
                        end
                        default: begin
                            if (fin) begin
                                n_r[0] = mk(R_DONE, '0, '0, 1'b1); n_cnt = 2'd1;
                            end
                        end
                    endcase
                    n_first = 1'b0;
                    if (fin) n_phase = PH_IDLE;
                end
                default: ;
            endcase
            if (len_done) begin
                if (len > {16'd0, room}) begin
                    n_r[0] = mk(R_ERR, '0, E_LEN_BUF, 1'b1); n_cnt = 2'd1;
                    n_phase = PH_IDLE;
                end else begin
                    n_crem = len; n_first = 1'b1; n_iacc = '0; n_aacc = '0;
                    n_phase = PH_CONTENT;
                    unique case (n_ekind)
                        K_HEADER: begin
                            n_r[0] = mk(R_LEN, {1'b0, len}, '0, 1'b1); n_cnt = 2'd1;
                            n_phase = PH_IDLE;
                        end
                        K_INT: begin
                            if (len == 32'd0) begin
                                n_r[0] = mk(R_ERR, '0, E_INT_ZERO, 1'b1); n_cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end else if (len > 32'(INT_BYTES)) begin
                                n_r[0] = mk(R_ERR, '0, E_INT_LONG, 1'b1); n_cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end
                        end
                        K_OID: begin
                            if (len == 32'd0) begin
                                n_r[0] = mk(R_ERR, '0, E_OID_ZERO, 1'b1); n_cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            if (len == 32'd0) begin
                                n_r[0] = mk(R_DONE, '0, '0, 1'b1); n_cnt = 2'd1;
                                n_phase = PH_IDLE;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_phase <= PH_IDLE; r_ekind <= '0; r_lbr <= '0; r_lacc <= '0;
            r_crem <= '0; r_iacc <= '0; r_aacc <= '0; r_first <= 1'b0;
            r_qn <= 2'd0;
        end else begin
            if (in_fire) begin
                r_iv <= 1'b1; r_in <= {s_axis_tdata, s_axis_tuser};
            end else if (consume) begin
                r_iv <= 1'b0;
            end
            // queue shift on pop, then append
            begin : q_update
                t_res q [MAXR];
                q = r_q;
                if (pop) begin
                    q[0] = r_q[1]; q[1] = r_q[2];
                end
                if (consume) begin
                    if (q_after == 2'd0) begin
                        q[0] = n_r[0]; q[1] = n_r[1];
                    end else begin
                        q[1] = n_r[0]; q[2] = n_r[1];
                    end
                end
                r_q <= q;
            end
            r_qn <= q_after + (consume ? n_cnt : 2'd0);
            if (consume) begin
                r_phase <= n_phase; r_ekind <= n_ekind; r_lbr <= n_lbr;
                r_lacc <= n_lacc; r_crem <= n_crem; r_iacc <= n_iacc;
                r_aacc <= n_aacc; r_first <= n_first;
            end
        end
    end

    assign m_axis_tvalid = (r_qn != 2'd0);
    assign m_axis_tdata  = {3'd0, r_q[0].err, r_q[0].value};
    assign m_axis_tuser  = r_q[0].kind;
    assign m_axis_tlast  = r_q[0].last;

endmodule

// ===== rtl/core/bertlv_checker.sv =====
// Checker: port-level properties of the BER TLV decoder, with its bind.
module bertlv_checker
    import bertlv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed under stall");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= R_ERR)
        else $error("bad result kind");
    a_errlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == R_ERR || m_axis_tuser == R_DONE)
        |-> m_axis_tlast)
        else $error("error or done without last");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");
endmodule

bind ber_tlv_element_decoder_unit bertlv_checker u_chk (.*);

// ===== tb/ber_tlv_element_decoder_unit_tb.sv =====
// Testbench for the streaming BER TLV element decoder: directed and random elements.
`timescale 1ns / 1ps

class ber_result_board;
    bertlv_pkg::t_res pending[$];
    int mismatches;
    int checked;

    function new();
        mismatches = 0;
        checked = 0;
    endfunction

    // predicted results of one accepted item
    function void note_item(bertlv_pkg::t_res res[$]);
        foreach (res[i]) pending.push_back(res[i]);
    endfunction

    function void check_result(logic [2:0] kind, logic [32:0] value, logic [3:0] err,
                               logic last);
        bertlv_pkg::t_res exp_r;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result kind=%0d value=%h err=%0d last=%0b",
                         kind, value, err, last);
            return;
        end
        exp_r = pending.pop_front();
        checked++;
        if (exp_r.kind !== kind || exp_r.value !== value || exp_r.err !== err ||
            exp_r.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp k=%0d v=%h e=%0d l=%0b, got k=%0d v=%h e=%0d l=%0b",
                         exp_r.kind, exp_r.value, exp_r.err, exp_r.last,
                         kind, value, err, last);
        end
    endfunction
endclass

module ber_tlv_element_decoder_unit_tb;
    import bertlv_pkg::*;

    localparam int WATCHDOG = 20000;

    // one stimulus item
    typedef struct {
        logic [2:0]  kind;
        logic        start;
        logic [7:0]  tag;
        logic [7:0]  bval;
        logic [15:0] left;
    } t_byte_item;

    typedef enum logic [1:0] {
        DP_IDLE, DP_LEN_FIRST, DP_LEN_MORE, DP_CONTENT
    } t_dec_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    ber_tlv_element_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ber_result_board board;
    t_byte_item      stim[$];
    int              idle_cycles;
    bit              send_done;
    bit              hold_off;
    int              items_sent;

    // decoder shadow state
    t_dec_phase  dec_phase;
    logic [2:0]  dec_kind;
    logic [2:0]  dec_len_cnt;
    logic [31:0] dec_len_acc;
    logic [31:0] dec_content_left;
    logic [31:0] dec_int_acc;
    logic [31:0] dec_arc_acc;
    logic        dec_first;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res mk_res(logic [2:0] k, logic [32:0] v, logic [3:0] e,
                                    logic l);
        t_res r;
        r.kind = k;
        r.value = v;
        r.err = e;
        r.last = l;
        return r;
    endfunction

    // length is complete; room is the bytes after the last length byte
    function automatic void finish_length(logic [31:0] len, logic [31:0] room,
                                          ref t_res res[$]);
        if (len > room) begin
            res.push_back(mk_res(R_ERR, '0, E_LEN_BUF, 1'b1));
            dec_phase = DP_IDLE;
            return;
        end
        dec_content_left = len;
        dec_first = 1'b1;
        dec_int_acc = '0;
        dec_arc_acc = '0;
        dec_phase = DP_CONTENT;
        case (dec_kind)
            K_HEADER: begin
                res.push_back(mk_res(R_LEN, {1'b0, len}, '0, 1'b1));
                dec_phase = DP_IDLE;
            end
            K_INT: begin
                if (len == 0 || len > INT_BYTES) begin
                    res.push_back(mk_res(R_ERR, '0, (len == 0) ? E_INT_ZERO : E_INT_LONG,
                                         1'b1));
                    dec_phase = DP_IDLE;
                end
            end
            K_OID: begin
                if (len == 0) begin
                    res.push_back(mk_res(R_ERR, '0, E_OID_ZERO, 1'b1));
                    dec_phase = DP_IDLE;
                end
            end
            default: begin
                if (len == 0) begin
                    res.push_back(mk_res(R_DONE, '0, '0, 1'b1));
                    dec_phase = DP_IDLE;
                end
            end
        endcase
    endfunction

    function automatic void decode_content(logic [7:0] b, ref t_res res[$]);
        logic fin;
        fin = (dec_content_left <= 1);
        dec_content_left = fin ? 32'd0 : dec_content_left - 1;
        case (dec_kind)
            K_INT: begin
                if (dec_first) dec_int_acc = b[7] ? 32'hFFFF_FFFF : 32'd0;
                dec_int_acc = {dec_int_acc[23:0], b};
                if (fin) res.push_back(mk_res(R_INT, {dec_int_acc[31], dec_int_acc},
                                              '0, 1'b1));
            end
            K_OCTETS: res.push_back(mk_res(R_BYTE, {25'd0, b}, '0, fin));
            K_OID: begin
                if (dec_first) begin
                    res.push_back(mk_res(R_ARC, 33'(b / 40), '0, 1'b0));
                    res.push_back(mk_res(R_ARC, 33'(b % 40), '0, fin));
                end else begin
                    dec_arc_acc = {dec_arc_acc[24:0], b[6:0]};
                    if (!b[7]) begin
                        res.push_back(mk_res(R_ARC, {1'b0, dec_arc_acc}, '0, fin));
                        dec_arc_acc = '0;
                    end else if (fin) begin
                        res.push_back(mk_res(R_ERR, '0, E_ARC_OPEN, 1'b1));
                    end
                end
            end
            default: if (fin) res.push_back(mk_res(R_DONE, '0, '0, 1'b1));
        endcase
        dec_first = 1'b0;
        if (fin) dec_phase = DP_IDLE;
    endfunction

    // predicts the results that one accepted item causes
    function automatic void decode_item(t_byte_item it, ref t_res res[$]);
        logic [31:0] room;
        logic [6:0]  cnt;
        room = (it.left != 0) ? 32'(it.left) - 1 : 32'd0;
        if (it.start) begin
            dec_kind = (it.kind <= K_OID) ? it.kind : K_SKIP;
            if (it.left == 0) begin
                res.push_back(mk_res(R_ERR, '0, E_END_TAG, 1'b1));
                dec_phase = DP_IDLE;
            end else if (dec_kind != K_SKIP && it.bval != it.tag) begin
                res.push_back(mk_res(R_ERR, '0, E_TAG, 1'b1));
                dec_phase = DP_IDLE;
            end else begin
                dec_phase = DP_LEN_FIRST;
            end
            return;
        end
        case (dec_phase)
            DP_LEN_FIRST: begin
                cnt = it.bval[6:0];
                if (it.left == 0) begin
                    res.push_back(mk_res(R_ERR, '0, E_END_LEN, 1'b1));
                    dec_phase = DP_IDLE;
                end else if (!it.bval[7]) begin
                    finish_length(32'(it.bval), room, res);
                end else if (cnt == 0 || cnt > LEN_BYTES || cnt > room) begin
                    res.push_back(mk_res(R_ERR, '0, (cnt == 0) ? E_INDEF :
                                         (cnt > LEN_BYTES) ? E_LEN_LARGE : E_LENF_BUF,
                                         1'b1));
                    dec_phase = DP_IDLE;
                end else begin
                    dec_len_cnt = cnt[2:0];
                    dec_len_acc = '0;
                    dec_phase = DP_LEN_MORE;
                end
            end
            DP_LEN_MORE: begin
                if (it.left == 0) begin
                    res.push_back(mk_res(R_ERR, '0, E_END_LEN, 1'b1));
                    dec_phase = DP_IDLE;
                end else begin
                    // saturate so a huge length always fails the buffer bound
                    if (dec_len_acc > 32'h00FF_FFFF) dec_len_acc = 32'hFFFF_FFFF;
                    else dec_len_acc = {dec_len_acc[23:0], it.bval};
                    if (dec_len_cnt > 0) dec_len_cnt--;
                    if (dec_len_cnt == 0) finish_length(dec_len_acc, room, res);
                end
            end
            DP_CONTENT: decode_content(it.bval, res);
            default: ;
        endcase
    endfunction

    function automatic t_byte_item mk_item(logic [2:0] k, logic s, logic [7:0] tg,
                                           logic [7:0] b, logic [15:0] l);
        t_byte_item it;
        it.kind = k;
        it.start = s;
        it.tag = tg;
        it.bval = b;
        it.left = l;
        return it;
    endfunction

    // pushes one element: tag, length bytes, content; bytes_left counts down
    task automatic queue_element(logic [2:0] k, logic [7:0] tg, logic [7:0] hdr[$],
                                 int slack);
        int base;
        base = hdr.size() + slack;
        foreach (hdr[i])
            stim.push_back(mk_item((i == 0) ? k : 3'($urandom_range(0, 7)), i == 0,
                                   (i == 0) ? tg : 8'($urandom), hdr[i],
                                   16'(base - i)));
    endtask

    task automatic queue_directed();
        logic [7:0] e[$];
        e = '{8'h30, 8'h03};                                   // header
        queue_element(K_HEADER, 8'h30, e, 3);
        e = '{8'h02, 8'h04, 8'h80, 8'h00, 8'h00, 8'h00};      // most negative int
        queue_element(K_INT, 8'h02, e, 0);
        e = '{8'h02, 8'h01, 8'h7F};
        queue_element(K_INT, 8'h02, e, 0);
        e = '{8'h02, 8'h00};                                   // int length zero
        queue_element(K_INT, 8'h02, e, 0);
        e = '{8'h02, 8'h05};                                   // int too long
        queue_element(K_INT, 8'h02, e, 9);
        e = '{8'h04, 8'h81, 8'h02, 8'hFF, 8'h00};              // long form octets
        queue_element(K_OCTETS, 8'h04, e, 0);
        e = '{8'h04, 8'h00};                                   // empty octets
        queue_element(K_OCTETS, 8'h04, e, 0);
        e = '{8'h06, 8'h04, 8'h2B, 8'h86, 8'h48, 8'h01};       // oid
        queue_element(K_OID, 8'h06, e, 0);
        e = '{8'h06, 8'h02, 8'hFF, 8'h8F};                     // unfinished arc
        queue_element(K_OID, 8'h06, e, 0);
        e = '{8'h06, 8'h00};
        queue_element(K_OID, 8'h06, e, 0);
        e = '{8'hAA, 8'h02, 8'h11, 8'h22};                     // skip, unknown kind
        queue_element(3'd7, 8'h00, e, 0);
        e = '{8'h31, 8'h80};                                   // indefinite
        queue_element(K_HEADER, 8'h31, e, 0);
        e = '{8'h31, 8'h85};                                   // count too big
        queue_element(K_HEADER, 8'h31, e, 9);
        e = '{8'h31, 8'h84};                                   // count over buffer
        queue_element(K_HEADER, 8'h31, e, 1);
        e = '{8'h31, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};       // all-ones length, over buffer
        queue_element(K_HEADER, 8'h31, e, 0);
        stim.push_back(mk_item(K_INT, 1'b1, 8'h02, 8'h03, 16'hFFFF));  // tag mismatch
        stim.push_back(mk_item(K_INT, 1'b1, 8'h02, 8'h02, 16'd0));     // empty at tag
        stim.push_back(mk_item(K_SKIP, 1'b0, 8'h00, 8'h55, 16'd5));    // ignored
        stim.push_back(mk_item(K_SKIP, 1'b1, 8'h12, 8'h99, 16'd3));
        stim.push_back(mk_item(K_SKIP, 1'b0, 8'h00, 8'h01, 16'd0));    // end at length
    endtask

    task automatic queue_random(int target);
        logic [7:0] e[$];
        int         n;
        int         kd;
        logic [7:0] tg;
        while (stim.size() < target) begin
            kd = $urandom_range(0, 7);
            tg = 8'($urandom);
            n = (kd == K_INT) ? $urandom_range(1, 4) : $urandom_range(0, 5);
            e = '{tg};
            if ($urandom_range(0, 3) == 0) begin
                e.push_back(8'h81);
                e.push_back(8'(n));
            end else begin
                e.push_back(8'(n));
            end
            repeat (n) e.push_back(8'($urandom));
            // noise: corrupt a byte, truncate or break the bounds
            case ($urandom_range(0, 9))
                0: e[$urandom_range(0, e.size() - 1)] = 8'($urandom);
                1: e = e[0:$urandom_range(0, e.size() - 1)];
                default: ;
            endcase
            queue_element(3'(kd), (kd == 2 || $urandom_range(0, 5)) ? tg : 8'($urandom), e,
                          ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 2));
            if ($urandom_range(0, 15) == 0)
                stim.push_back(mk_item(3'($urandom), 1'b0, 8'($urandom), 8'($urandom),
                                       16'($urandom)));
        end
    endtask

    task automatic send_items();
        t_byte_item it;
        t_res       res[$];
        int         gap;
        int         burst;
        burst = 0;
        while (stim.size() > 0) begin
            it = stim.pop_front();
            // stretches without gaps, then random gaps
            gap = (burst > 0) ? 0 : $urandom_range(0, 18);
            if (burst > 0) burst--;
            else if ($urandom_range(0, 9) == 0) burst = 20;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {it.left, it.bval, it.tag};
            s_axis_tuser <= {it.start, it.kind};
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            res = {};
            decode_item(it, res);
            board.note_item(res);
            items_sent++;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off early in the random part
    initial begin : sink
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 1)) stall = 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // result check on each accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata[32:0],
                               m_axis_tdata[36:33], m_axis_tlast);
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : main
        board = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_rst_n = 1'b0;
        idle_cycles = 0;
        send_done = 1'b0;
        hold_off = 1'b0;
        items_sent = 0;
        dec_phase = DP_IDLE;
        dec_kind = K_SKIP;
        dec_len_cnt = '0;
        dec_len_acc = '0;
        dec_content_left = '0;
        dec_int_acc = '0;
        dec_arc_acc = '0;
        dec_first = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        queue_directed();
        send_items();
        hold_off = 1'b1;
        queue_random(230 - items_sent);
        send_items();
        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d input items and %0d result items over all element kinds,",
                 items_sent, board.checked);
        $display("length forms, bounds errors and one long receiver hold-off");
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("mismatches: %0d", board.mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
